// ===== rtl/core/ilir_pkg.sv =====
// Shared types and constants for the indexed list insert/remove block.
// Used by indexed_list_insert_remove and the testbench; depends on nothing.
`default_nettype none

package ilir_pkg;

  localparam int unsigned IlirCapacity = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_GET    = 2'd2
  } ilir_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } ilir_status_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         index;
    logic signed [31:0] value;
  } ilir_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [7:0]         count;
  } ilir_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/ilir_ram.sv =====
// Entry store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module ilir_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AW    = $clog2(Depth)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ilir_step.sv =====
// Shared index step unit: next slot toward the end of a shift and the
// end-of-shift compare. Depends on nothing but its parameters.
`default_nettype none

module ilir_step #(
  parameter int unsigned AW = 6
) (
  input  wire logic          up_i,   // 1: walk toward the back (pop)
  input  wire logic [AW-1:0] k_i,
  input  wire logic [AW-1:0] tgt_i,
  output logic      [AW-1:0] nbr_o,
  output logic               done_o
);

  assign nbr_o  = up_i ? (k_i + AW'(1)) : (k_i - AW'(1));
  assign done_o = (k_i == tgt_i);

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_insert_remove.sv =====
// Indexed ordered list of signed 32-bit entries with insert, pop and get.
// Depends on ilir_pkg, ilir_ram and ilir_step.
//
// Usage: drive req_i and raise start_i; the request beat is taken at the
// clock edge where start_i is high and busy_o is low. Exactly one result
// beat follows on res_o, marked by res_valid_o for one cycle; the receiver
// cannot hold it off. busy_o stays high while a shift or a get is under way.
//
// Sequence, with n the number of entries that move:
//   rejected request (range/full/unused op): result registered straight from the accept
//   get:    a registered entry RAM read, then the result
//   insert: n moves, then the new value is written; n = count - index
//   pop:    n moves, then the fill count drops; n = count - index - 1
// Each moved entry costs a read and a write through the single-port-pair
// entry RAM, stepped by one shared index incrementer/comparator. A new
// request may be taken in the cycle the result is shown.
//
// Reset clears the fill count and the sequencer; entry contents are left
// as they are, since only slots below the count are ever read.
`default_nettype none

module indexed_list_insert_remove
  import ilir_pkg::*;
#(
  parameter int unsigned CAPACITY = IlirCapacity
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire ilir_req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output ilir_res_t      res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_MOVE,
    S_GET
  } state_e;

  state_e         state_q, state_d;
  logic [CW-1:0]  fill_q, fill_d;
  logic [AW-1:0]  k_q, k_d;
  logic [AW-1:0]  tgt_q, tgt_d;
  logic           up_q, up_d;
  logic [31:0]    val_q, val_d;
  logic           rvalid_d;
  ilir_res_t      res_d;

  logic           ram_we, ram_re;
  logic [AW-1:0]  ram_waddr, ram_raddr;
  logic [31:0]    ram_wdata, ram_rdata;
  logic [AW-1:0]  nbr;
  logic           done;

  logic [7:0]     fill8;
  logic [CW-1:0]  fill_m1;
  logic           in_range;

  assign fill8    = 8'(fill_q);
  assign fill_m1  = fill_q - CW'(1);
  assign in_range = (req_i.index < fill8);

  ilir_ram #(
    .Depth (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ilir_step #(
    .AW (AW)
  ) u_step (
    .up_i   (up_q),
    .k_i    (k_q),
    .tgt_i  (tgt_q),
    .nbr_o  (nbr),
    .done_o (done)
  );

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    k_d       = k_q;
    tgt_d     = tgt_q;
    up_d      = up_q;
    val_d     = val_q;
    rvalid_d  = 1'b0;
    res_d     = '{status: ST_RANGE, data: '0, count: fill8};
    ram_we    = 1'b0;
    ram_waddr = k_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = nbr;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_i.op)
            OP_INSERT: begin
              if (req_i.index > fill8) begin
                rvalid_d = 1'b1;
              end else if (fill_q == CW'(CAPACITY)) begin
                rvalid_d     = 1'b1;
                res_d.status = ST_FULL;
              end else begin
                k_d     = fill_q[AW-1:0];
                tgt_d   = req_i.index[AW-1:0];
                up_d    = 1'b0;
                val_d   = req_i.value;
                state_d = S_SHIFT;
              end
            end
            OP_POP: begin
              if (in_range) begin
                k_d     = req_i.index[AW-1:0];
                tgt_d   = fill_m1[AW-1:0];
                up_d    = 1'b1;
                state_d = S_SHIFT;
              end else begin
                rvalid_d = 1'b1;
              end
            end
            OP_GET: begin
              if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = req_i.index[AW-1:0];
                state_d   = S_GET;
              end else begin
                rvalid_d = 1'b1;
              end
            end
            default: begin
              rvalid_d = 1'b1;
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (done) begin
          // shift finished: drop the new value in, or retire the popped slot
          if (!up_q) begin
            ram_we    = 1'b1;
            ram_wdata = val_q;
            fill_d    = fill_q + CW'(1);
          end else begin
            fill_d    = fill_m1;
          end
          rvalid_d     = 1'b1;
          res_d.status = ST_OK;
          res_d.count  = 8'(fill_d);
          state_d      = S_IDLE;
        end else begin
          ram_re  = 1'b1;
          state_d = S_MOVE;
        end
      end
      S_MOVE: begin
        // neighbor read is back: write it into the current slot and advance
        ram_we  = 1'b1;
        k_d     = nbr;
        state_d = S_SHIFT;
      end
      S_GET: begin
        rvalid_d     = 1'b1;
        res_d.status = ST_OK;
        res_d.data   = ram_rdata;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      res_valid_o <= 1'b0;
      k_q         <= '0;
      tgt_q       <= '0;
      up_q        <= 1'b0;
      val_q       <= '0;
      res_o       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      res_valid_o <= rvalid_d;
      k_q         <= k_d;
      tgt_q       <= tgt_d;
      up_q        <= up_d;
      val_q       <= val_d;
      res_o       <= res_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // Every accepted beat either answers next cycle or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (res_valid_o || busy_o))
    else $error("accepted request neither answered nor in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.count <= 8'(CAPACITY)))
    else $error("result count above capacity");

  a_error_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.status != ST_OK)) |-> (res_o.data == '0))
    else $error("error result carries data");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> (res_valid_o || $stable(fill_q)))
    else $error("fill changed without a result");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for indexed_list_insert_remove: directed edge cases, fill/drain
// to capacity and a long random mix, each result checked against an in-bench list model.
// Depends on ilir_pkg and the indexed_list_insert_remove RTL.
module tb
  import ilir_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ListCap = IlirCapacity;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned RandomItems = 1750;
  localparam int unsigned PhaseLen = 150;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  ilir_req_t req_i = '0;
  logic      busy_o;
  logic      res_valid_o;
  ilir_res_t res_o;

  // list model: contents, length and results still to come out of the block
  logic signed [31:0] list_mem [ListCap];
  int unsigned        list_len = 0;
  ilir_res_t          pending_results [$];
  ilir_res_t          want_res;

  int unsigned fail_count = 0;
  int unsigned burst_left = 0;

  indexed_list_insert_remove #(
    .CAPACITY(ListCap)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic ilir_req_t make_req(logic [1:0] op, logic [7:0] idx,
                                         logic signed [31:0] val);
    ilir_req_t r;
    r.op    = op;
    r.index = idx;
    r.value = val;
    return r;
  endfunction

  // Apply one accepted request to the list model and return its result.
  function automatic ilir_res_t apply_request(ilir_req_t r);
    ilir_res_t   res;
    int unsigned k;
    res.status = ST_RANGE;
    res.data   = '0;
    case (r.op)
      OP_INSERT: begin
        if (r.index > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= ListCap) begin
          res.status = ST_FULL;
        end else begin
          for (k = list_len; k > r.index; k--) list_mem[k] = list_mem[k - 1];
          list_mem[r.index] = r.value;
          list_len++;
          res.status = ST_OK;
        end
      end
      OP_POP: begin
        if (r.index < list_len) begin
          for (k = r.index; k + 1 < list_len; k++) list_mem[k] = list_mem[k + 1];
          list_len--;
          res.status = ST_OK;
        end
      end
      OP_GET: begin
        if (r.index < list_len) begin
          res.data   = list_mem[r.index];
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    res.count = list_len[7:0];
    return res;
  endfunction

  task automatic record_failure(string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Between beats: either keep the burst going or drop start for a random gap.
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 80);
      end else begin
        burst_left = $urandom_range(1, 20);
        gap = $urandom_range(1, 8);
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Called at a rising edge; returns once the beat has been taken, after any pacing gap.
  task automatic send_request(ilir_req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(apply_request(r));
    pace_sender();
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position up to hi, otherwise anything the field holds.
  function automatic logic [7:0] pick_index(int hi);
    if (hi >= 0 && $urandom_range(0, 99) < 85) return 8'($urandom_range(0, hi));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_list();
    send_request(make_req(OP_GET, 8'd0, 32'sd0));
    send_request(make_req(OP_POP, 8'd0, 32'sd0));
    send_request(make_req(OP_INSERT, 8'd1, 32'sd5));
    send_request(make_req(OpUnused, 8'd0, $urandom));
  endtask

  task automatic test_edges();
    int unsigned i;
    send_request(make_req(OP_INSERT, 8'd0, 32'sh7fff_ffff));
    send_request(make_req(OP_INSERT, 8'd0, 32'sh8000_0000));
    send_request(make_req(OP_INSERT, 8'd2, -32'sd1));
    send_request(make_req(OP_INSERT, 8'd1, 32'sd0));
    send_request(make_req(OP_INSERT, 8'd5, 32'sd7));
    for (i = 0; i < 4; i++) send_request(make_req(OP_GET, i[7:0], 32'sd0));
    send_request(make_req(OP_GET, 8'd4, 32'sd0));
    send_request(make_req(OP_GET, 8'd255, 32'sd0));
    send_request(make_req(OP_POP, 8'd255, 32'sd0));
    send_request(make_req(OP_POP, 8'd4, 32'sd0));
    send_request(make_req(OP_POP, 8'd1, 32'sd0));
    send_request(make_req(OP_POP, 8'd2, 32'sd0));
    send_request(make_req(OP_POP, 8'd0, 32'sd0));
    send_request(make_req(OP_GET, 8'd0, 32'sd0));
    send_request(make_req(OpUnused, 8'd255, 32'shffff_ffff));
  endtask

  task automatic test_fill_and_drain();
    while (list_len < ListCap)
      send_request(make_req(OP_INSERT, 8'($urandom_range(0, list_len)), pick_value()));
    // full list: full status, but an index past the end still reports range first
    send_request(make_req(OP_INSERT, ListCap[7:0], pick_value()));
    send_request(make_req(OP_INSERT, 8'd0, pick_value()));
    send_request(make_req(OP_INSERT, ListCap[7:0] + 8'd1, pick_value()));
    send_request(make_req(OP_INSERT, 8'd255, pick_value()));
    send_request(make_req(OP_GET, ListCap[7:0] - 8'd1, 32'sd0));
    send_request(make_req(OP_POP, ListCap[7:0], 32'sd0));
    while (list_len > 0)
      send_request(make_req(OP_POP, 8'($urandom_range(0, list_len - 1)), 32'sd0));
  endtask

  task automatic test_random_mix();
    int unsigned n;
    int unsigned roll;
    bit          growing;
    for (n = 0; n < RandomItems; n++) begin
      growing = ((n / PhaseLen) % 2) == 0;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        send_request(make_req(OpUnused, 8'($urandom_range(0, 255)), $urandom));
      end else if (roll < 20) begin
        send_request(make_req(OP_GET, pick_index(int'(list_len) - 1), $urandom));
      end else if ((roll < 85) == growing) begin
        send_request(make_req(OP_INSERT, pick_index(int'(list_len)), pick_value()));
      end else begin
        send_request(make_req(OP_POP, pick_index(int'(list_len) - 1), $urandom));
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_results.size() == 0) begin
        record_failure($sformatf("unexpected result beat status=%0d data=%0d count=%0d",
                                 res_o.status, res_o.data, res_o.count));
      end else begin
        want_res = pending_results.pop_front();
        if (res_o.status !== want_res.status || res_o.data !== want_res.data ||
            res_o.count !== want_res.count) begin
          record_failure($sformatf(
            "expected status=%0d data=%0d count=%0d, got status=%0d data=%0d count=%0d",
            want_res.status, want_res.data, want_res.count,
            res_o.status, res_o.data, res_o.count));
        end
      end
    end
  end

  initial begin
    int unsigned waited;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_list();
    test_edges();
    test_fill_and_drain();
    test_random_mix();
    start_i <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0)
      record_failure($sformatf("%0d results never arrived", pending_results.size()));
    // catch any stray beat after the last one
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("indexed_list_insert_remove verification clean");
    end else begin
      $display("indexed_list_insert_remove verification failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("indexed_list_insert_remove verification failed");
    $finish;
  end

endmodule
